FILE: design/aes_counter_keystream_generator_macros.svh
// Assertion helpers for the top-level design file.
`ifndef AES_COUNTER_KEYSTREAM_GENERATOR_MACROS_SVH
`define AES_COUNTER_KEYSTREAM_GENERATOR_MACROS_SVH
// Implication checked on every rising clock edge, suppressed while reset is low.
`define ACKG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define ACKG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: design/ackg_pkg.sv
// ----------------------------------------------------------------------------
// ackg_pkg
// Types, constants and AES helper functions for the keystream generator.
// ----------------------------------------------------------------------------
package ackg_pkg;
    localparam int unsigned MAX_REQUEST_DEF = 64;
    localparam int unsigned BLK_BYTES = 16;
    localparam int unsigned CFG_W = 64;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned NUM_ROUNDS = 10;

    typedef enum logic [2:0] {
        CFG_KEY_HI = 3'd0,
        CFG_KEY_LO = 3'd1,
        CFG_CTR_HI = 3'd2,
        CFG_CTR_LO = 3'd3,
        CFG_LEN    = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_KEXP,
        ST_IDLE,
        ST_OUT,
        ST_WAIT
    } t_state;

    // Handshake between sequencer and cipher core.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_core_ctl;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Next round key from the previous one; rc is the round constant.
    function automatic logic [127:0] next_rkey(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        t  = sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h0};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // One cipher round without key addition; byte 0 is the top byte.
    function automatic logic [127:0] round_fn(input logic [127:0] s, input logic last);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) b[i] = s[127 - 8*i -: 8];
        for (int i = 0; i < 16; i++) t[i] = sbox(b[((((i >> 2) + (i & 3)) & 3) << 2) | (i & 3)]);
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = t[i];
        return r;
    endfunction
endpackage

FILE: design/ackg_stream_if.sv
// ----------------------------------------------------------------------------
// ackg_stream_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface ackg_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: design/aes_counter_keystream_generator.sv
// ----------------------------------------------------------------------------
// aes_counter_keystream_generator
// AES-128 counter-mode keystream generator, one byte per result.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel carries byte_count (1..64, larger values saturate,
//   zero gives nothing). The result channel returns one keystream byte per
//   item, with last_byte set on the final byte of each request.
//   Configuration writes set the seed; any write to a listed register
//   restarts generation and re-expands the key (requests not ready then).
//   When a fresh block is needed, the first byte waits for the cipher
//   core; when leftover bytes remain, it comes from the stored block.
//   Each 16-byte block is computed by the single shared round unit, and
//   no byte is shown while that unit runs.
//   One request is handled at a time; the request channel is not ready
//   until the last byte is taken. A stalled receiver holds the current
//   byte in the output register.
//   Reset loads an all-zero seed and expands the zero key.
// ----------------------------------------------------------------------------
`include "aes_counter_keystream_generator_macros.svh"
module aes_counter_keystream_generator
    import ackg_pkg::*;
#(
    parameter int unsigned MAX_REQUEST = MAX_REQUEST_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    ackg_stream_if.sink          req,
    ackg_stream_if.source        rsp
);
    localparam int unsigned RW = $clog2(MAX_REQUEST + 1);

    logic [63:0]  r_seed [4];
    logic [5:0]   r_len;
    logic [127:0] r_ctr, n_ctr;
    logic [127:0] r_spare;
    logic [3:0]   r_pos, n_pos;
    logic [RW-1:0] r_left, n_left;
    logic         r_kexp, n_kexp;
    logic         r_restart;
    t_state       r_state, n_state;
    logic [7:0]   r_byte, n_byte;
    logic         r_last, n_last;
    logic         r_start;
    t_core_ctl    w_ctl;
    logic [127:0] w_ct;
    logic [255:0] w_seed;
    logic [6:0]   w_req;
    logic         w_cfg_hit;

    // Seed bytes beyond the length read as zero.
    always_comb begin
        w_seed = {r_seed[0], r_seed[1], r_seed[2], r_seed[3]};
        for (int i = 0; i < 32; i++) begin
            if (6'(i) >= r_len) w_seed[255 - 8*i -: 8] = 8'h00;
        end
    end

    assign w_cfg_hit = i_cfg_we && (i_cfg_idx <= CFG_LEN);
    assign w_req = (req.data > 7'(MAX_REQUEST)) ? 7'(MAX_REQUEST) : req.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed    <= '{default: '0};
            r_len     <= '0;
            r_restart <= 1'b1;
        end else begin
            r_restart <= w_cfg_hit;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_KEY_HI: r_seed[0] <= i_cfg_data;
                    CFG_KEY_LO: r_seed[1] <= i_cfg_data;
                    CFG_CTR_HI: r_seed[2] <= i_cfg_data;
                    CFG_CTR_LO: r_seed[3] <= i_cfg_data;
                    CFG_LEN:    r_len <= (i_cfg_data[5:0] > 6'd32) ? 6'd32 : i_cfg_data[5:0];
                    default: ;
                endcase
            end
        end
    end

    ackg_core u_core (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_kexp (r_kexp),
        .i_key  (w_seed[255:128]),
        .i_start(r_start),
        .i_pt   (r_ctr),
        .o_ctl  (w_ctl),
        .o_ct   (w_ct)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_KEXP: if (!r_kexp && !w_ctl.busy && !r_restart) n_state = ST_IDLE;
            ST_IDLE: if (req.valid && w_req != '0) n_state = (r_pos == 4'd0) ? ST_WAIT : ST_OUT;
            ST_WAIT: if (w_ctl.done) n_state = ST_OUT;
            ST_OUT: begin
                if (rsp.ready) begin
                    if (r_last) n_state = ST_IDLE;
                    else if (r_pos == 4'd0) n_state = ST_WAIT;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (r_restart) n_state = ST_KEXP;
    end

    // Datapath and outputs
    always_comb begin
        n_ctr  = r_ctr;
        n_pos  = r_pos;
        n_left = r_left;
        n_kexp = 1'b0;
        n_byte = r_byte;
        n_last = r_last;
        unique case (r_state)
            ST_KEXP: ;
            ST_IDLE: begin
                if (req.valid && w_req != '0) begin
                    n_left = RW'(w_req);
                    if (r_pos != 4'd0) begin
                        n_byte = r_spare[127 - 8*r_pos -: 8];
                        n_last = (w_req == 7'd1);
                        n_pos  = r_pos + 4'd1;
                        n_left = RW'(w_req - 7'd1);
                    end
                end
            end
            ST_WAIT: begin
                if (w_ctl.done) begin
                    n_ctr  = r_ctr + 128'd1;
                    n_byte = w_ct[127:120];
                    n_last = (r_left == RW'(1));
                    n_pos  = 4'd1;
                    n_left = r_left - RW'(1);
                end
            end
            ST_OUT: begin
                if (rsp.ready && !r_last && r_pos != 4'd0) begin
                    n_byte = r_spare[127 - 8*r_pos -: 8];
                    n_last = (r_left == RW'(1));
                    n_pos  = r_pos + 4'd1;
                    n_left = r_left - RW'(1);
                end
            end
            default: ;
        endcase
        if (r_restart) begin
            n_ctr  = w_seed[127:0];
            n_pos  = '0;
            n_kexp = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_KEXP;
            r_pos   <= '0;
            r_kexp  <= 1'b0;
            r_start <= 1'b0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_kexp  <= n_kexp;
            r_left  <= n_left;
            r_start <= (n_state == ST_WAIT) && (r_state != ST_WAIT) && !r_restart;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctr  <= n_ctr;
        r_byte <= n_byte;
        r_last <= n_last;
        if (r_state == ST_WAIT && w_ctl.done) begin
            r_spare <= w_ct;
        end
    end

    assign req.ready = (r_state == ST_IDLE) && !r_restart;
    assign rsp.valid = (r_state == ST_OUT);
    assign rsp.data  = {r_byte, r_last};

    `ACKG_ASSERT_IMP(a_no_out_busy, i_clk, i_rst_n, rsp.valid, !w_ctl.busy,
        "result shown while cipher runs")
    `ACKG_ASSERT_IMP(a_req_idle, i_clk, i_rst_n, req.ready, !rsp.valid && !w_ctl.busy,
        "request taken while busy")
    `ACKG_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n,
        rsp.valid && rsp.ready && r_last && !r_restart, r_state == ST_IDLE,
        "no return to idle after last byte")
endmodule

FILE: design/ackg_ram.sv
// ----------------------------------------------------------------------------
// ackg_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ackg_ram #(
    parameter int unsigned WIDTH = 128,
    parameter int unsigned DEPTH = 11
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: design/ackg_core.sv
// ----------------------------------------------------------------------------
// ackg_core
// Iterative AES-128 encryptor: one shared round unit, round keys in a RAM.
// ----------------------------------------------------------------------------
module ackg_core
    import ackg_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_kexp,      // expand key from i_key
    input  logic [127:0]  i_key,
    input  logic          i_start,
    input  logic [127:0]  i_pt,
    output t_core_ctl     o_ctl,
    output logic [127:0]  o_ct
);
    logic [3:0]   r_rnd;
    logic         r_kbusy;
    logic         r_ebusy;
    logic [127:0] r_key;
    logic [127:0] r_st;
    logic [7:0]   r_rc;
    logic         r_done;
    logic [127:0] w_rk;
    logic [3:0]   w_addr;
    logic         w_we;

    // Key expansion writes round r_rnd; encryption reads the key one round ahead.
    assign w_we   = r_kbusy;
    assign w_addr = r_kbusy ? r_rnd : ((i_start && !r_ebusy) ? 4'd0 : r_rnd + 4'd1);

    ackg_ram #(.WIDTH(128), .DEPTH(NUM_ROUNDS + 1)) u_rk (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata(r_key),
        .o_rdata(w_rk)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kbusy <= 1'b0;
            r_ebusy <= 1'b0;
            r_done  <= 1'b0;
            r_rnd   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_kexp) begin
                r_kbusy <= 1'b1;
                r_ebusy <= 1'b0;
                r_rnd   <= '0;
                r_key   <= i_key;
                r_rc    <= 8'h01;
            end else if (r_kbusy) begin
                r_key <= next_rkey(r_key, r_rc);
                r_rc  <= xtime(r_rc);
                r_rnd <= r_rnd + 4'd1;
                if (r_rnd == 4'(NUM_ROUNDS)) begin
                    r_kbusy <= 1'b0;
                end
            end else if (i_start && !r_ebusy) begin
                r_ebusy <= 1'b1;
                r_rnd   <= '0;
                r_st    <= i_pt;
            end else if (r_ebusy) begin
                // round 0 data at rnd 0 holds key 0
                if (r_rnd == 4'd0) begin
                    r_st <= r_st ^ w_rk;
                end else begin
                    r_st <= round_fn(r_st, r_rnd == 4'(NUM_ROUNDS)) ^ w_rk;
                end
                r_rnd <= r_rnd + 4'd1;
                if (r_rnd == 4'(NUM_ROUNDS)) begin
                    r_ebusy <= 1'b0;
                    r_done  <= 1'b1;
                end
            end
        end
    end

    // Round function applied in the same cycle the key for that round arrives.
    assign o_ctl.start = i_start;
    assign o_ctl.busy  = r_kbusy | r_ebusy;
    assign o_ctl.done  = r_done;
    assign o_ct        = r_st;
endmodule
